// File: hw/rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Types and constants shared by the shape perimeter and area pipeline.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int LEN_W  = 16;
    localparam int FRAC_W = 8;
    localparam int PER_W  = 19;
    localparam int AREA_W = 26;

    // Heron radicand after the fixed right shift, and its square root.
    localparam int RAD_W  = 46;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    // Pi in Q2.60, split into two 31-bit halves for the multipliers.
    localparam logic [61:0] PI_Q60 = 62'h3243F6A8885A308D;
    localparam logic [30:0] PI_HI  = PI_Q60[61:31];
    localparam logic [30:0] PI_LO  = PI_Q60[30:0];

    localparam logic [1:0] KIND_TRI    = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;

    typedef struct packed {
        logic              invalid;
        logic              is_tri;
        logic [PER_W-1:0]  perimeter;
        logic [AREA_W-1:0] area;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        t_side            side;
    } t_mid;

endpackage

// File: hw/rtl/spa_if.sv
// ----------------------------------------------------------------------------
// spa_in_if / spa_out_if
// Valid/ready channels for shape words and result words.
// ----------------------------------------------------------------------------
interface spa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  shape_kind;
    logic [15:0] len_a;
    logic [15:0] len_b;
    logic [15:0] len_c;

    modport source (output valid, shape_kind, len_a, len_b, len_c, input ready);
    modport sink   (input valid, shape_kind, len_a, len_b, len_c, output ready);
endinterface

interface spa_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] perimeter_out;
    logic [25:0] area_out;
    logic        shape_invalid;

    modport source (output valid, perimeter_out, area_out, shape_invalid, input ready);
    modport sink   (input valid, perimeter_out, area_out, shape_invalid, output ready);
endinterface

// File: hw/rtl/spa_front.sv
// ----------------------------------------------------------------------------
// spa_front
// Four register stages: shape check, sums, products and the Heron radicand.
// ----------------------------------------------------------------------------
module spa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spa_in_if.sink        i_shape,
    output logic          o_valid,
    input  logic          i_ready,
    output spa_pkg::t_mid o_mid
);

    localparam int LW = spa_pkg::LEN_W;

    // Stage valid bits and the ready chain.
    logic r1_v, r2_v, r3_v, r4_v;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4        = !r4_v || i_ready;
    assign w_rdy3        = !r3_v || w_rdy4;
    assign w_rdy2        = !r2_v || w_rdy3;
    assign w_rdy1        = !r1_v || w_rdy2;
    assign i_shape.ready = w_rdy1;

    // Stage 1: checks, sums and the first narrow products.
    logic [LW:0]   n_ab, n_ac, n_bc;
    logic          n1_inv;
    logic          r1_inv, r1_tri, r1_circ;
    logic [LW+1:0] r1_s;
    logic [LW:0]   r1_x, r1_y, r1_z;
    logic [2*LW-1:0] r1_aa;
    logic [46:0]   r1_aph, r1_apl;
    logic [spa_pkg::PER_W-1:0] r1_sqper;

    always_comb begin
        n_ab = {1'b0, i_shape.len_a} + {1'b0, i_shape.len_b};
        n_ac = {1'b0, i_shape.len_a} + {1'b0, i_shape.len_c};
        n_bc = {1'b0, i_shape.len_b} + {1'b0, i_shape.len_c};
        case (i_shape.shape_kind)
            spa_pkg::KIND_TRI: begin
                n1_inv = (i_shape.len_a == '0) || (i_shape.len_b == '0) ||
                         (i_shape.len_c == '0) ||
                         (n_ab <= {1'b0, i_shape.len_c}) ||
                         (n_ac <= {1'b0, i_shape.len_b}) ||
                         (n_bc <= {1'b0, i_shape.len_a});
            end
            spa_pkg::KIND_SQUARE, spa_pkg::KIND_CIRCLE: begin
                n1_inv = (i_shape.len_a == '0);
            end
            default: begin
                n1_inv = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_shape.valid;
        end
        if (w_rdy1) begin
            r1_inv   <= n1_inv;
            r1_tri   <= (i_shape.shape_kind == spa_pkg::KIND_TRI);
            r1_circ  <= (i_shape.shape_kind == spa_pkg::KIND_CIRCLE);
            r1_s     <= {1'b0, n_ab} + {2'b0, i_shape.len_c};
            r1_x     <= n_bc - {1'b0, i_shape.len_a};
            r1_y     <= n_ac - {1'b0, i_shape.len_b};
            r1_z     <= n_ab - {1'b0, i_shape.len_c};
            r1_aa    <= (2*LW)'(i_shape.len_a) * (2*LW)'(i_shape.len_a);
            r1_aph   <= 47'(i_shape.len_a) * 47'(spa_pkg::PI_HI);
            r1_apl   <= 47'(i_shape.len_a) * 47'(spa_pkg::PI_LO);
            r1_sqper <= {1'b0, i_shape.len_a, 2'b00};
        end
    end

    // Stage 2: Heron half products, circle perimeter, square area.
    logic [77:0] n_cper;
    logic        r2_inv, r2_tri, r2_circ;
    logic [34:0] r2_u;
    logic [33:0] r2_v34;
    logic [62:0] r2_aaph, r2_aapl;
    logic [spa_pkg::PER_W-1:0] r2_per;
    logic [23:0] r2_sqarea;

    assign n_cper = {r1_aph, 31'b0} + {31'b0, r1_apl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
        if (w_rdy2) begin
            r2_inv    <= r1_inv;
            r2_tri    <= r1_tri;
            r2_circ   <= r1_circ;
            r2_u      <= 35'(r1_s) * 35'(r1_x);
            r2_v34    <= 34'(r1_y) * 34'(r1_z);
            r2_aaph   <= 63'(r1_aa) * 63'(spa_pkg::PI_HI);
            r2_aapl   <= 63'(r1_aa) * 63'(spa_pkg::PI_LO);
            r2_sqarea <= r1_aa[31:spa_pkg::FRAC_W];
            if (r1_tri) begin
                r2_per <= {1'b0, r1_s};
            end else if (r1_circ) begin
                r2_per <= n_cper[77:59];
            end else begin
                r2_per <= r1_sqper;
            end
        end
    end

    // Stage 3: full Heron product in two partial products; circle area.
    logic [93:0] n_carea;
    logic        r3_inv, r3_tri;
    logic [50:0] r3_uvl;
    logic [52:0] r3_uvh;
    logic [spa_pkg::PER_W-1:0]  r3_per;
    logic [spa_pkg::AREA_W-1:0] r3_area;

    assign n_carea = {r2_aaph, 31'b0} + {31'b0, r2_aapl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_rdy3) begin
            r3_v <= r2_v;
        end
        if (w_rdy3) begin
            r3_inv  <= r2_inv;
            r3_tri  <= r2_tri;
            r3_uvl  <= 51'(r2_u) * 51'(r2_v34[15:0]);
            r3_uvh  <= 53'(r2_u) * 53'(r2_v34[33:16]);
            r3_per  <= r2_per;
            r3_area <= r2_circ ? n_carea[93:68] : {2'b0, r2_sqarea};
        end
    end

    // Stage 4: sum the partial products and drop 2*FRAC+4 bits.
    logic [68:0] n_prod;
    spa_pkg::t_mid r4_mid;

    assign n_prod = {r3_uvh, 16'b0} + {18'b0, r3_uvl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_rdy4) begin
            r4_v <= r3_v;
        end
        if (w_rdy4) begin
            r4_mid.rad            <= n_prod[65:20];
            r4_mid.side.invalid   <= r3_inv;
            r4_mid.side.is_tri    <= r3_tri;
            r4_mid.side.perimeter <= r3_per;
            r4_mid.side.area      <= r3_area;
        end
    end

    assign o_valid = r4_v;
    assign o_mid   = r4_mid;

endmodule

// File: hw/rtl/spa_isqrt.sv
// ----------------------------------------------------------------------------
// spa_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module spa_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  spa_pkg::t_mid              i_mid,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [spa_pkg::ROOT_W-1:0] o_root,
    output spa_pkg::t_side             o_side
);

    localparam int NS = spa_pkg::ROOT_W;
    localparam int RW = spa_pkg::RAD_W;
    localparam int MW = spa_pkg::REM_W;

    logic              r_v    [NS];
    logic [RW-1:0]     r_rad  [NS];
    logic [MW-1:0]     r_rem  [NS];
    logic [NS-1:0]     r_root [NS];
    spa_pkg::t_side    r_side [NS];
    logic              w_rdy  [NS+1];

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           p_v;
        logic [RW-1:0]  p_rad;
        logic [MW-1:0]  p_rem;
        logic [NS-1:0]  p_root;
        spa_pkg::t_side p_side;
        logic [MW-1:0]  n_sh, n_trial;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rad  = i_mid.rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_mid.side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        // Bring down the next two radicand bits and try a one in this place.
        assign n_sh    = {p_rem[MW-3:0], p_rad[RW-1:RW-2]};
        assign n_trial = {1'b0, p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= p_v;
            end
            if (w_rdy[k]) begin
                r_rad[k]  <= {p_rad[RW-3:0], 2'b00};
                r_side[k] <= p_side;
                if (n_sh >= n_trial) begin
                    r_rem[k]  <= n_sh - n_trial;
                    r_root[k] <= {p_root[NS-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_sh;
                    r_root[k] <= {p_root[NS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// File: hw/rtl/shape_perimeter_area_top.sv
// ----------------------------------------------------------------------------
// shape_perimeter_area_top
// Perimeter and area of a triangle, square or circle, one shape per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel    Dir  Word
// i_shape    in   shape_kind, len_a, len_b, len_c (Q8.8)
// o_result   out  perimeter_out, area_out (Q.8), shape_invalid
//
// The pipeline has four arithmetic stages, 23 square-root stages (one root bit
// each) and the output register. One word is accepted every cycle while the output is not stalled.
// Reset clears only the valid bits. A stalled output fills the stages behind it
// one by one; each stage holds its word until the next stage can take it.
// ----------------------------------------------------------------------------
module shape_perimeter_area_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spa_in_if.sink     i_shape,
    spa_out_if.source  o_result
);

    logic                       w_mid_v, w_mid_rdy;
    spa_pkg::t_mid              w_mid;
    logic                       w_sq_v, w_sq_rdy;
    logic [spa_pkg::ROOT_W-1:0] w_root;
    spa_pkg::t_side             w_side;

    spa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shape (i_shape),
        .o_valid (w_mid_v),
        .i_ready (w_mid_rdy),
        .o_mid   (w_mid)
    );

    spa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_v),
        .o_ready (w_mid_rdy),
        .i_mid   (w_mid),
        .o_valid (w_sq_v),
        .i_ready (w_sq_rdy),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    logic                        r_ov, r_oinv;
    logic [spa_pkg::PER_W-1:0]   r_oper;
    logic [spa_pkg::AREA_W-1:0]  r_oarea;

    assign w_sq_rdy = !r_ov || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_sq_rdy) begin
            r_ov <= w_sq_v;
        end
        if (w_sq_rdy) begin
            r_oinv <= w_side.invalid;
            if (w_side.invalid) begin
                r_oper  <= '0;
                r_oarea <= '0;
            end else begin
                r_oper  <= w_side.perimeter;
                r_oarea <= w_side.is_tri ? spa_pkg::AREA_W'(w_root) : w_side.area;
            end
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.perimeter_out = r_oper;
    assign o_result.area_out      = r_oarea;
    assign o_result.shape_invalid = r_oinv;

endmodule

// File: hw/rtl/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker
// Port-level checks on the result channel of the shape pipeline.
// ----------------------------------------------------------------------------
module spa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [18:0] i_perimeter,
    input logic [25:0] i_area,
    input logic        i_invalid
);

    // A rejected shape carries zero results.
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_invalid) |-> (i_perimeter == '0 && i_area == '0))
        else $error("invalid word with non-zero result");

    // An accepted shape always has a non-zero perimeter.
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_invalid) |-> (i_perimeter != '0))
        else $error("valid shape with zero perimeter");

    // Nothing leaves the pipeline straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid just after reset");

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind shape_perimeter_area_top spa_checker u_spa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_perimeter (o_result.perimeter_out),
    .i_area      (o_result.area_out),
    .i_invalid   (o_result.shape_invalid)
);
